>>> hdl/segment_circle_occlusion_test_assert.svh
// Assertion macros for the checker file.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef SEGMENT_CIRCLE_OCCLUSION_TEST_ASSERT_SVH
`define SEGMENT_CIRCLE_OCCLUSION_TEST_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define SCO_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define SCO_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> hdl/sco_pkg.sv
package sco_pkg;

   localparam int COORD_W = 8;
   localparam int WALL_W  = 3 * COORD_W;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int MUL_W   = 18;
   localparam int ACC_W   = 37;
   localparam int SQ_W    = 17;
   localparam int R2_W    = 16;
   localparam int CR_W    = 18;
   localparam int CRSQ_W  = 35;
   localparam int RL_W    = 33;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LEN0,
      ST_LEN1,
      ST_RD,
      ST_LOAD,
      ST_DA0,
      ST_DA1,
      ST_DB0,
      ST_DB1,
      ST_R2,
      ST_CR0,
      ST_CR1,
      ST_CRSQ,
      ST_RL,
      ST_PJ0,
      ST_PJ1,
      ST_DECIDE,
      ST_RESP
   } state_type;

endpackage

>>> hdl/sco_req_if.sv
interface sco_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] center_x;
   logic [7:0] center_y;
   logic [7:0] radius;
   logic [7:0] target_x;
   logic [7:0] target_y;
   logic [7:0] seeker_x;
   logic [7:0] seeker_y;

   modport source (
      output valid, op, center_x, center_y, radius,
             target_x, target_y, seeker_x, seeker_y,
      input  ready
   );
   modport sink (
      input  valid, op, center_x, center_y, radius,
             target_x, target_y, seeker_x, seeker_y,
      output ready
   );
endinterface

>>> hdl/sco_rsp_if.sv
interface sco_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink (input valid, visible, output ready);
endinterface

>>> hdl/sco_ram.sv
module sco_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/segment_circle_occlusion_test.sv
// Segment/circle occlusion test. A table of up to MAX_WALLS circular walls
// {center_x, center_y, radius} sits in a single-port-write, registered-read
// RAM; each request beat carries an op. Clear empties the table and append
// stores one wall (dropped when the table is full); both return no response
// beat and leave the block ready again at once. A query returns one
// response beat with visible = 1 when no stored wall blocks the segment
// from the target point to the seeker point. All tests are exact integer
// compares of squared distances and projections. Every product goes through
// one shared 18x18 signed multiply-accumulate unit under a small sequencer:
// a query first forms the segment length, then steps through each wall
// (RAM read, load, 11 products, decision), stops at the first blocking
// wall, and hands the result to the response register, waiting there while
// an earlier answer is still not taken. The request side stays busy for the
// whole query. The response register parts the two sides: a new request is
// taken while an earlier answer still waits for rsp ready. There is no
// clearing pass; only entries below the wall count are ever read.
module segment_circle_occlusion_test #(
   parameter int MAX_WALLS = 128
) (
   input  logic      clock,
   input  logic      reset,
   sco_req_if.sink   req_chan,
   sco_rsp_if.source rsp_chan
);
   import sco_pkg::*;

   localparam int CNT_W = $clog2(MAX_WALLS + 1);
   localparam int IDX_W = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;

   // sequencer
   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] idx_next;

   // query operands
   logic [COORD_W-1:0] ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;

   // per-wall operands and partial results
   logic signed [DIFF_W-1:0] cax_ff, cax_in, cay_ff, cay_in;
   logic signed [DIFF_W-1:0] cbx_ff, cbx_in, cby_ff, cby_in;
   logic [COORD_W-1:0]       r_ff, r_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [SQ_W-1:0]          da2_ff, da2_in, db2_ff, db2_in, len2_ff, len2_in;
   logic [R2_W-1:0]          r2_ff, r2_in;
   logic signed [CR_W-1:0]   cr_ff, cr_in, proj_ff, proj_in;
   logic [CRSQ_W-1:0]        crsq_ff, crsq_in;
   logic [RL_W-1:0]          rl_ff, rl_in;
   logic                     vis_ff, vis_in;

   // response register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_visible_ff, rsp_visible_in;

   // shared multiply-accumulate unit
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] prod;
   logic signed [ACC_W-1:0]   prod_ext, mac_sum;
   logic                      mac_add, mac_neg;

   // wall table
   logic                  ram_wr_en, ram_rd_en;
   logic [WALL_W-1:0]     ram_wr_data, ram_rd_data;

   logic req_take, table_full, blocks, query_done, rsp_free;

   assign req_take   = req_chan.valid && req_chan.ready;
   assign table_full = (count_ff >= CNT_W'(MAX_WALLS));
   assign idx_next   = idx_ff + CNT_W'(1);
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.visible = rsp_visible_ff;

   assign ram_wr_en   = req_take && (req_chan.op == OP_APPEND) && !table_full;
   assign ram_wr_data = {req_chan.center_x, req_chan.center_y, req_chan.radius};

   sco_ram #(
      .WIDTH (WALL_W),
      .DEPTH (MAX_WALLS)
   ) u_wall_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign prod     = mul_a * mul_b;
   assign prod_ext = ACC_W'(prod);
   assign mac_sum  = (mac_add ? acc_ff : '0) + (mac_neg ? -prod_ext : prod_ext);

   // Wall verdict: a crossing blocks; both ends in or on never blocks;
   // otherwise block when the line is within the radius and the foot of
   // the perpendicular lies strictly between the ends.
   always_comb begin
      logic a_incl, b_incl, a_strict, b_strict, a_out, b_out, near;
      a_incl   = (da2_ff <= SQ_W'(r2_ff));
      b_incl   = (db2_ff <= SQ_W'(r2_ff));
      a_strict = (da2_ff < SQ_W'(r2_ff));
      b_strict = (db2_ff < SQ_W'(r2_ff));
      a_out    = !a_incl;
      b_out    = !b_incl;
      near     = (len2_ff != '0) && (crsq_ff <= CRSQ_W'(rl_ff))
                 && (proj_ff > CR_W'(0))
                 && (proj_ff < $signed({1'b0, len2_ff}));
      blocks   = !(a_incl && b_incl)
                 && ((a_strict && b_out) || (a_out && b_strict) || near);
   end

   assign query_done = blocks || (idx_next == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_chan.op == OP_QUERY)) begin
               state_in = ST_LEN0;
            end
         end
         ST_LEN0:  state_in = ST_LEN1;
         ST_LEN1:  state_in = (count_ff == '0) ? ST_RESP : ST_RD;
         ST_RD:    state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_DA0;
         ST_DA0:   state_in = ST_DA1;
         ST_DA1:   state_in = ST_DB0;
         ST_DB0:   state_in = ST_DB1;
         ST_DB1:   state_in = ST_R2;
         ST_R2:    state_in = ST_CR0;
         ST_CR0:   state_in = ST_CR1;
         ST_CR1:   state_in = ST_CRSQ;
         ST_CRSQ:  state_in = ST_RL;
         ST_RL:    state_in = ST_PJ0;
         ST_PJ0:   state_in = ST_PJ1;
         ST_PJ1:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = query_done ? ST_RESP : ST_RD;
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: operand selection for the multiply-accumulate unit
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      mac_add   = 1'b0;
      mac_neg   = 1'b0;
      ram_rd_en = 1'b0;
      case (state_ff)
         ST_LEN0: begin
            mul_a = MUL_W'(dx_ff);
            mul_b = MUL_W'(dx_ff);
         end
         ST_LEN1: begin
            mul_a   = MUL_W'(dy_ff);
            mul_b   = MUL_W'(dy_ff);
            mac_add = 1'b1;
         end
         ST_RD: ram_rd_en = 1'b1;
         ST_DA0: begin
            mul_a = MUL_W'(cax_ff);
            mul_b = MUL_W'(cax_ff);
         end
         ST_DA1: begin
            mul_a   = MUL_W'(cay_ff);
            mul_b   = MUL_W'(cay_ff);
            mac_add = 1'b1;
         end
         ST_DB0: begin
            mul_a = MUL_W'(cbx_ff);
            mul_b = MUL_W'(cbx_ff);
         end
         ST_DB1: begin
            mul_a   = MUL_W'(cby_ff);
            mul_b   = MUL_W'(cby_ff);
            mac_add = 1'b1;
         end
         ST_R2: begin
            mul_a = MUL_W'(r_ff);
            mul_b = MUL_W'(r_ff);
         end
         ST_CR0: begin
            mul_a = MUL_W'(dx_ff);
            mul_b = MUL_W'(cay_ff);
         end
         ST_CR1: begin
            mul_a   = MUL_W'(dy_ff);
            mul_b   = MUL_W'(cax_ff);
            mac_add = 1'b1;
            mac_neg = 1'b1;
         end
         ST_CRSQ: begin
            mul_a = cr_ff;
            mul_b = cr_ff;
         end
         ST_RL: begin
            mul_a = MUL_W'(r2_ff);
            mul_b = MUL_W'(len2_ff);
         end
         ST_PJ0: begin
            mul_a = MUL_W'(cax_ff);
            mul_b = MUL_W'(dx_ff);
         end
         ST_PJ1: begin
            mul_a   = MUL_W'(cay_ff);
            mul_b   = MUL_W'(dy_ff);
            mac_add = 1'b1;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // datapath and bookkeeping next values
   always_comb begin
      count_in       = count_ff;
      idx_in         = idx_ff;
      ax_in          = ax_ff;
      ay_in          = ay_ff;
      bx_in          = bx_ff;
      by_in          = by_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      cax_in         = cax_ff;
      cay_in         = cay_ff;
      cbx_in         = cbx_ff;
      cby_in         = cby_ff;
      r_in           = r_ff;
      acc_in         = mac_sum;
      da2_in         = da2_ff;
      db2_in         = db2_ff;
      len2_in        = len2_ff;
      r2_in          = r2_ff;
      cr_in          = cr_ff;
      crsq_in        = crsq_ff;
      rl_in          = rl_ff;
      proj_in        = proj_ff;
      vis_in         = vis_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_visible_in = rsp_visible_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_chan.op)
                  OP_CLEAR:  count_in = '0;
                  OP_APPEND: begin
                     if (!table_full) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_QUERY: begin
                     ax_in  = req_chan.target_x;
                     ay_in  = req_chan.target_y;
                     bx_in  = req_chan.seeker_x;
                     by_in  = req_chan.seeker_y;
                     dx_in  = $signed(DIFF_W'(req_chan.seeker_x) - DIFF_W'(req_chan.target_x));
                     dy_in  = $signed(DIFF_W'(req_chan.seeker_y) - DIFF_W'(req_chan.target_y));
                     idx_in = '0;
                     vis_in = 1'b1;
                  end
                  default: vis_in = vis_ff;
               endcase
            end
         end
         ST_LEN1:  len2_in = mac_sum[SQ_W-1:0];
         ST_LOAD: begin
            // unpack {x, y, r} and form center offsets from both ends
            cax_in = $signed(DIFF_W'(ram_rd_data[WALL_W-1 -: COORD_W]) - DIFF_W'(ax_ff));
            cay_in = $signed(DIFF_W'(ram_rd_data[2*COORD_W-1 -: COORD_W]) - DIFF_W'(ay_ff));
            cbx_in = $signed(DIFF_W'(ram_rd_data[WALL_W-1 -: COORD_W]) - DIFF_W'(bx_ff));
            cby_in = $signed(DIFF_W'(ram_rd_data[2*COORD_W-1 -: COORD_W]) - DIFF_W'(by_ff));
            r_in   = ram_rd_data[COORD_W-1:0];
         end
         ST_DA1:   da2_in  = mac_sum[SQ_W-1:0];
         ST_DB1:   db2_in  = mac_sum[SQ_W-1:0];
         ST_R2:    r2_in   = mac_sum[R2_W-1:0];
         ST_CR1:   cr_in   = mac_sum[CR_W-1:0];
         ST_CRSQ:  crsq_in = mac_sum[CRSQ_W-1:0];
         ST_RL:    rl_in   = mac_sum[RL_W-1:0];
         ST_PJ1:   proj_in = mac_sum[CR_W-1:0];
         ST_DECIDE: begin
            idx_in = idx_next;
            if (blocks) begin
               vis_in = 1'b0;
            end
         end
         ST_RESP: begin
            // hold the answer until the response register is free
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_visible_in = vis_ff;
            end
         end
         default: vis_in = vis_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff          <= ax_in;
      ay_ff          <= ay_in;
      bx_ff          <= bx_in;
      by_ff          <= by_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      cax_ff         <= cax_in;
      cay_ff         <= cay_in;
      cbx_ff         <= cbx_in;
      cby_ff         <= cby_in;
      r_ff           <= r_in;
      acc_ff         <= acc_in;
      da2_ff         <= da2_in;
      db2_ff         <= db2_in;
      len2_ff        <= len2_in;
      r2_ff          <= r2_in;
      cr_ff          <= cr_in;
      crsq_ff        <= crsq_in;
      rl_ff          <= rl_in;
      proj_ff        <= proj_in;
      vis_ff         <= vis_in;
      rsp_visible_ff <= rsp_visible_in;
   end
endmodule

>>> hdl/sco_checker.sv
`include "segment_circle_occlusion_test_assert.svh"

module sco_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_op,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_visible
);
   import sco_pkg::*;

   logic take_query, take_other, rsp_stall, quiet_other;

   assign take_query  = req_valid && req_ready && (req_op == OP_QUERY);
   assign take_other  = req_valid && req_ready && (req_op != OP_QUERY);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign quiet_other = take_other && !rsp_valid;

   // a stalled answer holds
   `SCO_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_visible), "beat moved")
   // a query occupies the sequencer
   `SCO_ASSERT_NEXT(a_query_busy, take_query, !req_ready, "ready while a query is in progress")
   // no answer can appear right after a query is taken
   `SCO_ASSERT_NEXT(a_query_latency, take_query, !$rose(rsp_valid), "response too early")
   // clear and append never produce a beat
   `SCO_ASSERT_NEXT(a_no_rsp_other, quiet_other, !rsp_valid, "response from clear or append")
endmodule

bind segment_circle_occlusion_test sco_checker u_sco_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_op      (req_chan.op),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_visible (rsp_chan.visible)
);
